@@ sv/fsd_pkg.sv @@
// shared constants, types and arithmetic helpers for the rgb error diffusion dither
package fsd_pkg;

	localparam int MAX_WIDTH = 2048;
	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int LW_W = 12;
	localparam int PIX_W = 8;
	localparam int ERR_W = 9;
	localparam int NUM_CH = 3;
	localparam int MEM_W = ERR_W * NUM_CH;

	localparam int X_W = 17;
	localparam int RECIP_SHIFT = 26;
	localparam logic [17:0] RECIP_510 = 18'((2 ** RECIP_SHIFT) / 510);
	localparam logic [X_W-1:0] DIV_510 = X_W'(510);
	localparam logic [X_W-1:0] ROUND_255 = X_W'(255);

	typedef logic signed [ERR_W-1:0] err_t;
	typedef logic [PIX_W-1:0] pix_t;

	typedef enum logic [0:0] {
		REG_LINE_WIDTH = 1'b0,
		REG_LEVELS     = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic first_row;
		logic has_left;
		logic has_right;
		logic last;
	} pix_ctx_t;

	function automatic pix_t add_err(pix_t v, err_t e, logic [2:0] k);
		logic signed [13:0] ew;
		logic signed [13:0] kw;
		logic signed [13:0] s;
		pix_t r;
		ew = 14'(e);
		kw = $signed({11'd0, k});
		s = $signed({2'b00, v, 4'b0000}) + ew * kw;
		if (s < 0) begin
			r = '0;
		end else if (s[13:12] != 2'b00) begin
			r = 8'hFF;
		end else begin
			r = s[11:4];
		end
		return r;
	endfunction

endpackage

@@ sv/floyd_steinberg_rgb_dither.sv @@
// floyd-steinberg rgb dither: line error store, per pixel sequencer and level step divider
//
// Pixels enter in raster order on the s_axis side, one word per pixel with tuser marking
// the first pixel of a frame, and leave quantized on the m_axis side in the same order.
// The next input word is taken only after the current pixel is written back: the error
// additions run one neighbor per cycle, then the quantizer steps through the level
// product, the reciprocal multiply, the correction and the step scaling in states of
// their own. Writing the levels register starts a bitwise restoring step division during
// which no pixel and no further configuration word is taken. The output word sits in its
// own register, so the next pixel is taken while a result waits; a stalled output holds
// the sequencer only at its write-back. The line store is not cleared: the first row of a
// frame ignores it, so no clearing pass is needed after reset.
module floyd_steinberg_rgb_dither
	import fsd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // red_in, green_in, blue_in
	input  logic        s_axis_tuser,  // frame_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,  // red_out, green_out, blue_out
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [11:0] cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_MUL,
		ST_REC,
		ST_COR,
		ST_SCALE,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [MEM_W-1:0] mem [MAX_WIDTH];
	logic [MEM_W-1:0] rd_up_q;
	logic [MEM_W-1:0] rd_ur_q;

	logic [LW_W-1:0]  lw_q;
	pix_t             lv_q;
	pix_t             step_q;

	logic             div_busy_q;
	logic [2:0]       div_cnt_q;
	pix_t             div_rem_q;
	pix_t             div_quo_q;
	pix_t             div_d_q;

	logic [COL_W-1:0] column_q;
	logic             first_row_q;
	err_t             left_q [NUM_CH];
	err_t             ul_q [NUM_CH];
	logic [COL_W-1:0] col_q;
	pix_ctx_t         ctx_q;
	logic [1:0]       add_step_q;

	pix_t             val_q [NUM_CH];
	logic [X_W-1:0]   x_q [NUM_CH];
	pix_t             q0_q [NUM_CH];
	pix_t             r_q [NUM_CH];
	pix_t             quant_q [NUM_CH];
	err_t             cur_q [NUM_CH];

	logic             out_valid_q;
	logic [23:0]      out_data_q;

	logic             in_acc;
	logic             cfg_acc;
	logic [COL_W-1:0] col_eff;
	logic [LW_W-1:0]  w_eff;
	logic [LW_W-1:0]  col_next;
	logic             has_right_c;
	logic [COL_W-1:0] col_plus;
	logic             mem_we;
	logic [MEM_W-1:0] mem_wd;
	logic [8:0]       div_trial;
	logic             div_bit;
	pix_t             div_quo_next;

	pix_t             add_val [NUM_CH];
	logic [X_W-1:0]   x_next [NUM_CH];
	pix_t             q0_next [NUM_CH];
	pix_t             r_next [NUM_CH];
	pix_t             q_next [NUM_CH];
	err_t             cur_next [NUM_CH];

	assign s_axis_tready = (state_q == ST_IDLE) && !div_busy_q;
	assign cfg_ready     = !div_busy_q;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign cfg_acc       = cfg_valid && cfg_ready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	always_comb begin
		if (lw_q == '0) begin
			w_eff = LW_W'(1);
		end else if (lw_q > LW_W'(MAX_WIDTH)) begin
			w_eff = LW_W'(MAX_WIDTH);
		end else begin
			w_eff = lw_q;
		end
		col_eff     = s_axis_tuser ? '0 : column_q;
		col_next    = LW_W'(col_eff) + LW_W'(1);
		has_right_c = col_next < w_eff;
		col_plus    = col_eff + COL_W'(1);
	end

	always_comb begin
		div_trial    = {div_rem_q, 1'b1};
		div_bit      = div_trial >= {1'b0, div_d_q};
		div_quo_next = {div_quo_q[6:0], div_bit};
	end

	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			err_t       e;
			logic [2:0] k;
			logic       en;
			logic [15:0] lvv;
			logic [34:0] p;
			logic [X_W-1:0] rem;
			logic [15:0] qs;
			case (add_step_q)
				2'd0: begin
					e  = ul_q[ch];
					k  = 3'd1;
					en = !ctx_q.first_row && ctx_q.has_left;
				end
				2'd1: begin
					e  = rd_up_q[ch*ERR_W +: ERR_W];
					k  = 3'd5;
					en = !ctx_q.first_row;
				end
				2'd2: begin
					e  = rd_ur_q[ch*ERR_W +: ERR_W];
					k  = 3'd3;
					en = !ctx_q.first_row && ctx_q.has_right;
				end
				default: begin
					e  = left_q[ch];
					k  = 3'd7;
					en = ctx_q.has_left;
				end
			endcase
			add_val[ch] = en ? add_err(val_q[ch], e, k) : val_q[ch];

			lvv         = lv_q * val_q[ch];
			x_next[ch]  = {lvv, 1'b0} + ROUND_255;

			p           = 35'(x_q[ch]) * 35'(RECIP_510);
			q0_next[ch] = p[RECIP_SHIFT+7:RECIP_SHIFT];

			rem         = x_q[ch] - X_W'(X_W'(q0_q[ch]) * DIV_510);
			r_next[ch]  = q0_q[ch] + PIX_W'(rem >= DIV_510);

			qs           = r_q[ch] * step_q;
			q_next[ch]   = qs[7:0];
			cur_next[ch] = $signed({1'b0, val_q[ch]}) - $signed({1'b0, q_next[ch]});
		end
	end

	always_comb begin
		mem_we = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);
		for (int ch = 0; ch < NUM_CH; ch++) begin
			mem_wd[ch*ERR_W +: ERR_W] = cur_q[ch];
		end
	end

	// line error store
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[col_q] <= mem_wd;
		end
		if (in_acc) begin
			rd_up_q <= mem[col_eff];
			rd_ur_q <= mem[col_plus];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			lw_q        <= LW_W'(128);
			lv_q        <= PIX_W'(1);
			step_q      <= PIX_W'(255);
			div_busy_q  <= 1'b0;
			div_cnt_q   <= '0;
			div_rem_q   <= '0;
			div_quo_q   <= '0;
			div_d_q     <= PIX_W'(1);
			column_q    <= '0;
			first_row_q <= 1'b1;
			col_q       <= '0;
			ctx_q       <= '0;
			add_step_q  <= '0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			for (int ch = 0; ch < NUM_CH; ch++) begin
				left_q[ch] <= '0;
				ul_q[ch]   <= '0;
			end
		end else begin
			if (out_valid_q && m_axis_tready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_acc) begin
				case (reg_idx_t'(cfg_index))
					REG_LINE_WIDTH: begin
						lw_q <= cfg_data;
					end
					REG_LEVELS: begin
						lv_q       <= (cfg_data[7:0] == '0) ? PIX_W'(1) : cfg_data[7:0];
						div_d_q    <= (cfg_data[7:0] == '0) ? PIX_W'(1) : cfg_data[7:0];
						div_busy_q <= 1'b1;
						div_cnt_q  <= '0;
						div_rem_q  <= '0;
						div_quo_q  <= '0;
					end
					default: begin
					end
				endcase
			end

			// restoring division of 255 by the level count
			if (div_busy_q) begin
				div_rem_q <= div_bit ? 8'(div_trial - {1'b0, div_d_q}) : div_trial[7:0];
				div_quo_q <= div_quo_next;
				div_cnt_q <= div_cnt_q + 3'd1;
				if (div_cnt_q == 3'd7) begin
					div_busy_q <= 1'b0;
					step_q     <= div_quo_next;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						for (int ch = 0; ch < NUM_CH; ch++) begin
							val_q[ch] <= s_axis_tdata[ch*PIX_W +: PIX_W];
							if (s_axis_tuser) begin
								left_q[ch] <= '0;
							end
						end
						ctx_q.first_row <= s_axis_tuser || first_row_q;
						ctx_q.has_left  <= col_eff != '0;
						ctx_q.has_right <= has_right_c;
						ctx_q.last      <= !has_right_c;
						if (s_axis_tuser) begin
							first_row_q <= 1'b1;
						end
						col_q      <= col_eff;
						add_step_q <= '0;
						state_q    <= ST_ADD;
					end
				end
				ST_ADD: begin
					for (int ch = 0; ch < NUM_CH; ch++) begin
						val_q[ch] <= add_val[ch];
					end
					add_step_q <= add_step_q + 2'd1;
					if (add_step_q == 2'd3) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					for (int ch = 0; ch < NUM_CH; ch++) begin
						x_q[ch] <= x_next[ch];
					end
					state_q <= ST_REC;
				end
				ST_REC: begin
					for (int ch = 0; ch < NUM_CH; ch++) begin
						q0_q[ch] <= q0_next[ch];
					end
					state_q <= ST_COR;
				end
				ST_COR: begin
					for (int ch = 0; ch < NUM_CH; ch++) begin
						r_q[ch] <= r_next[ch];
					end
					state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					for (int ch = 0; ch < NUM_CH; ch++) begin
						quant_q[ch] <= q_next[ch];
						cur_q[ch]   <= cur_next[ch];
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {quant_q[2], quant_q[1], quant_q[0]};
						for (int ch = 0; ch < NUM_CH; ch++) begin
							ul_q[ch]   <= rd_up_q[ch*ERR_W +: ERR_W];
							left_q[ch] <= ctx_q.last ? err_t'(0) : cur_q[ch];
						end
						if (ctx_q.last) begin
							column_q    <= '0;
							first_row_q <= 1'b0;
						end else begin
							column_q    <= col_q + COL_W'(1);
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ tb/tb_floyd_steinberg_rgb_dither.sv @@
// self-checking testbench for the floyd-steinberg rgb dither with its own error diffusion predictor
module tb_floyd_steinberg_rgb_dither;
	import fsd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE_CYCLES = 12;
	localparam int STALL_LIMIT = 1000;
	localparam int RANDOM_WORDS = 530;
	localparam int PRINT_LIMIT = 40;

	typedef enum logic [1:0] {
		OP_PIXEL,
		OP_CONFIG,
		OP_DRAIN
	} stim_kind_t;

	typedef struct {
		stim_kind_t kind;
		pix_t r;
		pix_t g;
		pix_t b;
		logic sof;
		reg_idx_t idx;
		logic [LW_W-1:0] val;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [23:0] s_axis_tdata = '0;  // red_in, green_in, blue_in
	logic s_axis_tuser = 1'b0;  // frame_start
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;  // red_out, green_out, blue_out
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic cfg_index = 1'b0;
	logic [11:0] cfg_data = '0;

	floyd_steinberg_rgb_dither uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	stim_t stim_q[$];
	logic [23:0] dithered_q[$];
	int mismatches = 0;

	// generator view of the effective width, to keep the line store from being read unwritten
	int gen_width = 128;
	logic force_sof = 1'b0;

	// predictor state
	logic [LW_W-1:0] width_reg;
	pix_t levels_reg;
	err_t err_line[MAX_WIDTH][NUM_CH];
	err_t left_err[NUM_CH];
	err_t upper_left[NUM_CH];
	int col_pos;
	logic top_row;

	int in_hold = 0;
	int settle = 0;
	logic in_burst = 1'b0;
	int out_hold = 0;
	logic out_burst = 1'b0;
	int stuck = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	task automatic flag_mismatch(input string what);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("error at %0t: %s", $realtime, what);
	endtask

	function automatic int spread_add(input int v, input err_t e, input int k);
		int s;
		s = v * 16 + int'(e) * k;
		if (s < 0)
			return 0;
		s = s >>> 4;
		return (s > 255) ? 255 : s;
	endfunction

	task automatic dither_pixel(input logic [23:0] word, input logic sof);
		int w;
		int lv;
		int col;
		int ch;
		int v;
		int q;
		logic has_left;
		logic has_right;
		err_t above[NUM_CH];
		err_t above_right[NUM_CH];
		err_t fresh[NUM_CH];
		logic [23:0] px;
		w = (width_reg == 0) ? 1 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg));
		lv = (levels_reg == 0) ? 1 : int'(levels_reg);
		if (sof) begin
			col_pos = 0;
			top_row = 1'b1;
			left_err = '{default: '0};
		end
		col = col_pos;
		has_left = col > 0;
		has_right = col + 1 < w;
		for (ch = 0; ch < NUM_CH; ch++) begin
			above[ch] = err_line[col][ch];
			above_right[ch] = (col + 1 < MAX_WIDTH) ? err_line[col + 1][ch] : '0;
			v = word[8*ch +: 8];
			if (!top_row) begin
				if (has_left)
					v = spread_add(v, upper_left[ch], 1);
				v = spread_add(v, above[ch], 5);
				if (has_right)
					v = spread_add(v, above_right[ch], 3);
			end
			if (has_left)
				v = spread_add(v, left_err[ch], 7);
			q = ((2 * lv * v + 255) / 510) * (255 / lv);
			fresh[ch] = err_t'(v - q);
			px[8*ch +: 8] = pix_t'(q);
		end
		upper_left = above;
		err_line[col] = fresh;
		left_err = fresh;
		if (col + 1 >= w) begin
			col_pos = 0;
			top_row = 1'b0;
			left_err = '{default: '0};
		end else begin
			col_pos = col + 1;
		end
		dithered_q.push_back(px);
	endtask

	function automatic pix_t rand_chan();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			default: return pix_t'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic push_pixel(input pix_t r, input pix_t g, input pix_t b, input logic sof);
		stim_t op;
		op.kind = OP_PIXEL;
		op.r = r;
		op.g = g;
		op.b = b;
		op.sof = sof | force_sof;
		op.idx = REG_LINE_WIDTH;
		op.val = '0;
		force_sof = 1'b0;
		stim_q.push_back(op);
	endtask

	task automatic push_config(input reg_idx_t idx, input logic [LW_W-1:0] val);
		stim_t op;
		int w;
		op.kind = OP_DRAIN;
		op.r = '0;
		op.g = '0;
		op.b = '0;
		op.sof = 1'b0;
		op.idx = idx;
		op.val = val;
		stim_q.push_back(op);
		op.kind = OP_CONFIG;
		stim_q.push_back(op);
		if (idx == REG_LINE_WIDTH) begin
			w = (val == 0) ? 1 : ((val > MAX_WIDTH) ? MAX_WIDTH : int'(val));
			// a wider row would read line store entries this frame never wrote
			if (w > gen_width)
				force_sof = 1'b1;
			gen_width = w;
		end
	endtask

	// driver: pixel and configuration words
	always @(posedge clk or negedge arst_n) begin
		logic pv;
		logic cv;
		stim_t op;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			s_axis_tuser <= 1'b0;
			cfg_valid <= 1'b0;
			cfg_index <= REG_LINE_WIDTH;
			cfg_data <= '0;
			in_hold = 0;
			settle = 0;
			width_reg = 12'd128;
			levels_reg = 8'd1;
			col_pos = 0;
			top_row = 1'b1;
			left_err = '{default: '0};
			upper_left = '{default: '0};
		end else begin
			pv = s_axis_tvalid;
			cv = cfg_valid;
			if (s_axis_tvalid && s_axis_tready) begin
				dither_pixel(s_axis_tdata, s_axis_tuser);
				pv = 1'b0;
				if ($urandom_range(0, 39) == 0)
					in_burst = ~in_burst;
				in_hold = in_burst ? 0 : $urandom_range(0, 13);
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_LINE_WIDTH)
					width_reg = cfg_data;
				else
					levels_reg = cfg_data[7:0];
				cv = 1'b0;
			end
			if (!pv && !cv && stim_q.size() != 0) begin
				if (in_hold > 0) begin
					in_hold--;
				end else begin
					case (stim_q[0].kind)
						OP_PIXEL: begin
							op = stim_q.pop_front();
							s_axis_tdata <= {op.b, op.g, op.r};
							s_axis_tuser <= op.sof;
							pv = 1'b1;
						end
						OP_CONFIG: begin
							op = stim_q.pop_front();
							cfg_index <= op.idx;
							cfg_data <= op.val;
							cv = 1'b1;
						end
						default: begin
							if (dithered_q.size() == 0) begin
								if (settle == SETTLE_CYCLES) begin
									void'(stim_q.pop_front());
									settle = 0;
								end else begin
									settle++;
								end
							end
						end
					endcase
				end
			end
			s_axis_tvalid <= pv;
			cfg_valid <= cv;
		end
	end

	// monitor: checks each output word against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		logic nr;
		logic [23:0] want;
		string names[NUM_CH];
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			out_hold = 0;
		end else begin
			names = '{"red", "green", "blue"};
			nr = m_axis_tready;
			if (m_axis_tvalid && m_axis_tready) begin
				if (dithered_q.size() == 0) begin
					flag_mismatch($sformatf("unexpected word %h", m_axis_tdata));
				end else begin
					want = dithered_q.pop_front();
					for (int ch = 0; ch < NUM_CH; ch++)
						if (m_axis_tdata[8*ch +: 8] !== want[8*ch +: 8])
							flag_mismatch($sformatf("%s got %0d want %0d", names[ch],
								m_axis_tdata[8*ch +: 8], want[8*ch +: 8]));
				end
				if ($urandom_range(0, 39) == 0)
					out_burst = ~out_burst;
				out_hold = out_burst ? 0 : $urandom_range(0, 13);
				nr = (out_hold == 0);
			end else if (!nr) begin
				if (out_hold > 0)
					out_hold--;
				nr = (out_hold == 0);
			end
			m_axis_tready <= nr;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
			(cfg_valid && cfg_ready)) begin
			stuck = 0;
		end else begin
			stuck++;
			if (stuck == STALL_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		int n_rand;
		int n;
		int eff;
		int mode;
		logic [LW_W-1:0] wcfg;
		logic [LW_W-1:0] lcfg;
		pix_t base_r;
		pix_t base_g;
		pix_t base_b;
		logic sof;

		foreach (err_line[i, j])
			err_line[i][j] = '0;

		// reset widths and levels, rounding boundary at one level
		push_pixel(8'd0, 8'd0, 8'd0, 1'b1);
		push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		push_pixel(8'd128, 8'd127, 8'd1, 1'b0);

		// three rows of three: edges, upper and left errors
		push_config(REG_LINE_WIDTH, 12'd3);
		push_config(REG_LEVELS, {4'hF, 8'd4});
		push_pixel(8'd255, 8'd0, 8'd128, 1'b1);
		push_pixel(8'd0, 8'd255, 8'd64, 1'b0);
		push_pixel(8'd200, 8'd100, 8'd30, 1'b0);
		push_pixel(8'd10, 8'd250, 8'd127, 1'b0);
		push_pixel(8'd255, 8'd255, 8'd255, 1'b0);
		push_pixel(8'd0, 8'd0, 8'd0, 1'b0);
		push_pixel(8'd90, 8'd160, 8'd220, 1'b0);
		push_pixel(8'd128, 8'd128, 8'd128, 1'b0);
		push_pixel(8'd33, 8'd66, 8'd99, 1'b0);

		// zero width and zero levels
		push_config(REG_LINE_WIDTH, 12'd0);
		push_config(REG_LEVELS, 12'd0);
		push_pixel(8'd77, 8'd200, 8'd5, 1'b1);
		push_pixel(8'd255, 8'd0, 8'd255, 1'b0);
		push_pixel(8'd1, 8'd254, 8'd128, 1'b0);

		// width narrowed in the middle of a row
		push_config(REG_LINE_WIDTH, 12'd5);
		push_config(REG_LEVELS, 12'd2);
		push_pixel(8'd50, 8'd150, 8'd250, 1'b1);
		push_pixel(8'd240, 8'd16, 8'd128, 1'b0);
		push_pixel(8'd99, 8'd99, 8'd99, 1'b0);
		push_config(REG_LINE_WIDTH, 12'd2);
		push_pixel(8'd0, 8'd255, 8'd0, 1'b0);
		push_pixel(8'd255, 8'd0, 8'd255, 1'b0);
		push_pixel(8'd180, 8'd70, 8'd20, 1'b0);

		n_rand = 0;
		while (n_rand < RANDOM_WORDS) begin
			case ($urandom_range(0, 19))
				0: wcfg = 12'd0;
				1: wcfg = 12'($urandom_range(2049, 4095));
				2: wcfg = 12'($urandom_range(65, 2048));
				3, 4, 5: wcfg = 12'($urandom_range(13, 64));
				default: wcfg = 12'($urandom_range(1, 12));
			endcase
			case ($urandom_range(0, 7))
				0: lcfg = {4'($urandom), 8'd0};
				1: lcfg = {4'($urandom), 8'd1};
				2: lcfg = {4'($urandom), 8'd255};
				3: lcfg = {4'($urandom), 8'd2};
				default: lcfg = {4'($urandom), 8'($urandom_range(0, 255))};
			endcase
			case ($urandom_range(0, 3))
				0: push_config(REG_LINE_WIDTH, wcfg);
				1: push_config(REG_LEVELS, lcfg);
				default: begin
					if ($urandom_range(0, 1)) begin
						push_config(REG_LINE_WIDTH, wcfg);
						push_config(REG_LEVELS, lcfg);
					end else begin
						push_config(REG_LEVELS, lcfg);
						push_config(REG_LINE_WIDTH, wcfg);
					end
				end
			endcase
			eff = gen_width;
			if (eff <= 64)
				n = eff * $urandom_range(2, 4) + $urandom_range(0, eff);
			else
				n = $urandom_range(3, 30);
			if (n > 150)
				n = 150;
			if (n > RANDOM_WORDS - n_rand)
				n = RANDOM_WORDS - n_rand;
			mode = $urandom_range(0, 2);
			base_r = rand_chan();
			base_g = rand_chan();
			base_b = rand_chan();
			for (int i = 0; i < n; i++) begin
				sof = (i == 0 && $urandom_range(0, 7) != 0) || ($urandom_range(0, 59) == 0);
				if (mode == 0)
					push_pixel(base_r, base_g, base_b, sof);
				else
					push_pixel(rand_chan(), rand_chan(), rand_chan(), sof);
			end
			n_rand += n;
		end

		begin
			stim_t op;
			op.kind = OP_DRAIN;
			op.r = '0;
			op.g = '0;
			op.b = '0;
			op.sof = 1'b0;
			op.idx = REG_LINE_WIDTH;
			op.val = '0;
			stim_q.push_back(op);
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (stim_q.size() != 0 || dithered_q.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && dithered_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
